FILE: rtl/blcm_pkg.sv
// Shared constants, types and curve tables for the backlight curve mapper.
package blcm_pkg;

   localparam int BREAKPOINTS = 41;
   localparam int LEVEL_SPAN  = 4096;

   localparam int LEVEL_W   = 12;
   localparam int REQ_W     = 16;
   localparam int POINT_W   = 10;
   localparam int PROD_W    = POINT_W + LEVEL_W;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 1;

   localparam int CURVE_FULL = 1023;

   localparam logic [LEVEL_W-1:0] LEVEL_CEIL   = 12'd4095;
   localparam logic [LEVEL_W-1:0] LEVEL_FLOOR  = 12'd5;
   localparam logic [LEVEL_W-1:0] CHARGE_LEVEL = 12'd2047;
   localparam logic [LEVEL_W-1:0] STORED_RESET = 12'd1023;
   localparam logic [LEVEL_W-1:0] MAX_RESET    = 12'd3276;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGING  = 1'd1;

   localparam int SEG_COUNT = BREAKPOINTS - 1;
   localparam int SEG_W     = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
   localparam int BIT_W     = (SEG_W > 1) ? $clog2(SEG_W) : 1;
   localparam int PT_W      = $clog2(BREAKPOINTS);

   localparam int DIV_STEPS = LEVEL_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int SCALE_OPS = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SRCH_MUL,
      ST_SRCH_CMP,
      ST_SCALE,
      ST_MULT,
      ST_DIV,
      ST_INTERP,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OPD_PS,
      OPD_PE,
      OPD_VS,
      OPD_VE
   } scale_opd_type;

   typedef struct packed {
      logic             load_req;
      logic             prep;
      logic             srch_mul;
      logic             srch_cmp;
      logic [BIT_W-1:0] srch_bit;
      logic             scale_issue;
      scale_opd_type    issue_opd;
      logic             scale_capture;
      scale_opd_type    capture_opd;
      logic             mult_start;
      logic             div_step;
      logic             interp_load;
      logic             emit;
   } dp_cmd_type;

   typedef struct packed {
      logic recover;
      logic needs_curve;
   } dp_status_type;

   function automatic logic [POINT_W-1:0] curve_pos(input logic [PT_W-1:0] idx);
      logic [POINT_W-1:0] p;
      case (idx)
         0:  p = 10'd0;    1:  p = 10'd4;    2:  p = 10'd99;   3:  p = 10'd144;
         4:  p = 10'd187;  5:  p = 10'd227;  6:  p = 10'd264;  7:  p = 10'd300;
         8:  p = 10'd334;  9:  p = 10'd366;  10: p = 10'd397;  11: p = 10'd427;
         12: p = 10'd456;  13: p = 10'd484;  14: p = 10'd511;  15: p = 10'd537;
         16: p = 10'd563;  17: p = 10'd587;  18: p = 10'd611;  19: p = 10'd635;
         20: p = 10'd658;  21: p = 10'd680;  22: p = 10'd702;  23: p = 10'd723;
         24: p = 10'd744;  25: p = 10'd764;  26: p = 10'd784;  27: p = 10'd804;
         28: p = 10'd823;  29: p = 10'd842;  30: p = 10'd861;  31: p = 10'd879;
         32: p = 10'd897;  33: p = 10'd915;  34: p = 10'd933;  35: p = 10'd950;
         36: p = 10'd967;  37: p = 10'd984;  38: p = 10'd1000; 39: p = 10'd1016;
         40: p = 10'd1023;
         default: p = 10'd0;
      endcase
      return p;
   endfunction

   function automatic logic [POINT_W-1:0] curve_val(input logic [PT_W-1:0] idx);
      logic [POINT_W-1:0] v;
      case (idx)
         0:  v = 10'd0;    1:  v = 10'd4;    2:  v = 10'd6;    3:  v = 10'd14;
         4:  v = 10'd24;   5:  v = 10'd37;   6:  v = 10'd52;   7:  v = 10'd69;
         8:  v = 10'd87;   9:  v = 10'd107;  10: v = 10'd128;  11: v = 10'd150;
         12: v = 10'd173;  13: v = 10'd197;  14: v = 10'd222;  15: v = 10'd248;
         16: v = 10'd275;  17: v = 10'd302;  18: v = 10'd330;  19: v = 10'd358;
         20: v = 10'd387;  21: v = 10'd416;  22: v = 10'd446;  23: v = 10'd477;
         24: v = 10'd507;  25: v = 10'd539;  26: v = 10'd570;  27: v = 10'd602;
         28: v = 10'd634;  29: v = 10'd667;  30: v = 10'd700;  31: v = 10'd733;
         32: v = 10'd767;  33: v = 10'd801;  34: v = 10'd835;  35: v = 10'd869;
         36: v = 10'd903;  37: v = 10'd938;  38: v = 10'd973;  39: v = 10'd1008;
         40: v = 10'd1023;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/blcm_dp.sv
// Datapath: registers, curve search, breakpoint scaling, interpolation divider, output word.
module blcm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_cmd,
   input  logic [blcm_pkg::REQ_W-1:0]           req_level,
   input  logic                                 csr_write,
   input  logic [blcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [blcm_pkg::CSR_W-1:0]           csr_data,
   input  blcm_pkg::dp_cmd_type                 cmd,
   output blcm_pkg::dp_status_type              status,
   output logic [3:0]                           rsp_level_high,
   output logic [7:0]                           rsp_level_low,
   output logic [blcm_pkg::LEVEL_W-1:0]         rsp_applied_level
);

   localparam int LW = blcm_pkg::LEVEL_W;
   localparam int PW = blcm_pkg::PROD_W;
   localparam int SW = blcm_pkg::SEG_W;
   localparam int TW = blcm_pkg::PT_W;

   function automatic logic [LW-1:0] div1023(input logic [PW-1:0] x);
      logic [PW:0]   t;
      logic [LW-1:0] q0;
      logic [PW-1:0] r0;
      t  = {1'b0, x} + (PW+1)'(x >> 10) + (PW+1)'(x >> 20);
      q0 = t[LW+9:10];
      r0 = x - ((PW'(q0) << 10) - PW'(q0));
      return (r0 >= PW'(blcm_pkg::CURVE_FULL)) ? q0 + LW'(1) : q0;
   endfunction

   logic [LW-1:0] max_ff, max_in;
   logic          charging_ff, charging_in;
   logic [LW-1:0] stored_ff, stored_in;
   logic          recover_ff, recover_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [PW-1:0] lim_ff, lim_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [LW-1:0] ps_ff, ps_in, pe_ff, pe_in, vs_ff, vs_in, ve_ff, ve_in;
   logic [LW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [LW-1:0] out_ff, out_in;

   logic [LW-1:0]         clamped;
   logic [SW-1:0]         cand;
   logic                  cand_ok;
   logic [TW-1:0]         idx_pt, idx_nx;
   logic [blcm_pkg::POINT_W-1:0] point;
   logic [LW:0]           lvl1;
   logic [LW-1:0]         scaled, dv, dl, den;
   logic [2*LW-1:0]       prod24;
   logic [LW:0]           trial;
   logic                  ge, oos;
   logic [LW:0]           interp_sum;
   logic [LW-1:0]         post, final_level;

   always_comb begin
      clamped = (req_level > blcm_pkg::REQ_W'(blcm_pkg::LEVEL_CEIL))
                ? blcm_pkg::LEVEL_CEIL : req_level[LW-1:0];
      cand    = idx_ff | (SW'(1) << cmd.srch_bit);
      cand_ok = cand <= SW'(blcm_pkg::SEG_COUNT - 1);
      idx_pt  = TW'(idx_ff);
      idx_nx  = idx_pt + TW'(1);
      lvl1    = {1'b0, cur_ff} + (LW+1)'(1);
      scaled  = div1023(prod_ff);
      dv      = ve_ff - vs_ff;
      dl      = cur_ff - ps_ff;
      den     = pe_ff - ps_ff;
      prod24  = (2*LW)'(dv) * (2*LW)'(dl);
      trial   = {rem_ff, quo_ff[LW-1]};
      ge      = trial >= {1'b0, den};
      oos     = cur_ff > pe_ff;
      interp_sum = {1'b0, vs_ff} + {1'b0, quo_ff};
   end

   always_comb begin
      if (cmd.srch_mul) begin
         point = blcm_pkg::curve_pos(TW'(cand));
      end else begin
         case (cmd.issue_opd)
            blcm_pkg::OPD_PS: point = blcm_pkg::curve_pos(idx_pt);
            blcm_pkg::OPD_PE: point = blcm_pkg::curve_pos(idx_nx);
            blcm_pkg::OPD_VS: point = blcm_pkg::curve_val(idx_pt);
            blcm_pkg::OPD_VE: point = blcm_pkg::curve_val(idx_nx);
            default:          point = blcm_pkg::curve_pos(idx_pt);
         endcase
      end
   end

   always_comb begin
      post = cur_ff;
      if (post != '0 && post < blcm_pkg::LEVEL_FLOOR) begin
         post = blcm_pkg::LEVEL_FLOOR;
      end
      if (charging_ff && post != '0) begin
         post = blcm_pkg::CHARGE_LEVEL;
      end
      final_level = recover_ff ? stored_ff : post;
   end

   always_comb begin
      max_in      = max_ff;
      charging_in = charging_ff;
      if (csr_write) begin
         case (csr_index)
            blcm_pkg::CSR_MAX_LEVEL: max_in = csr_data[LW-1:0];
            blcm_pkg::CSR_CHARGING:  charging_in = csr_data[0];
            default: ;
         endcase
      end

      recover_in = cmd.load_req ? req_cmd : recover_ff;
      cur_in     = cur_ff;
      if (cmd.load_req) begin
         cur_in = clamped;
      end else if (cmd.interp_load) begin
         if (oos) begin
            cur_in = '0;
         end else if (den == '0) begin
            cur_in = vs_ff;
         end else begin
            cur_in = interp_sum[LW-1:0];
         end
      end

      lim_in = cmd.prep ? ((PW'(lvl1) << 10) - PW'(lvl1)) : lim_ff;

      idx_in = idx_ff;
      if (cmd.prep) begin
         idx_in = '0;
      end else if (cmd.srch_cmp && cand_ok && prod_ff < lim_ff) begin
         idx_in = cand;
      end

      prod_in = (cmd.srch_mul || cmd.scale_issue) ? PW'(point) * PW'(max_ff) : prod_ff;

      ps_in = ps_ff;
      pe_in = pe_ff;
      vs_in = vs_ff;
      ve_in = ve_ff;
      if (cmd.scale_capture) begin
         case (cmd.capture_opd)
            blcm_pkg::OPD_PS: ps_in = scaled;
            blcm_pkg::OPD_PE: pe_in = scaled;
            blcm_pkg::OPD_VS: vs_in = scaled;
            blcm_pkg::OPD_VE: ve_in = scaled;
            default: ;
         endcase
      end

      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.mult_start) begin
         rem_in = prod24[2*LW-1:LW];
         quo_in = prod24[LW-1:0];
      end else if (cmd.div_step) begin
         rem_in = ge ? LW'(trial - {1'b0, den}) : trial[LW-1:0];
         quo_in = {quo_ff[LW-2:0], ge};
      end

      out_in    = cmd.emit ? final_level : out_ff;
      stored_in = (cmd.emit && !recover_ff) ? post : stored_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff      <= blcm_pkg::MAX_RESET;
         charging_ff <= 1'b0;
         stored_ff   <= blcm_pkg::STORED_RESET;
      end else begin
         max_ff      <= max_in;
         charging_ff <= charging_in;
         stored_ff   <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      recover_ff <= recover_in;
      cur_ff     <= cur_in;
      lim_ff     <= lim_in;
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      ps_ff      <= ps_in;
      pe_ff      <= pe_in;
      vs_ff      <= vs_in;
      ve_ff      <= ve_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_ff     <= out_in;
   end

   assign status.recover     = recover_ff;
   assign status.needs_curve = (cur_ff != '0) && (cur_ff < max_ff)
                               && (32'(cur_ff) < blcm_pkg::LEVEL_SPAN);

   assign rsp_level_high    = out_ff[LW-1:8];
   assign rsp_level_low     = out_ff[7:0];
   assign rsp_applied_level = out_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && den != '0 && !oos) |-> (rem_ff < den))
      else $error("divider remainder reached the divisor");

   a_interp_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.interp_load && den != '0 && !oos) |-> (interp_sum <= {1'b0, ve_ff}))
      else $error("interpolated level beyond segment end value");

endmodule

FILE: rtl/blcm_ctrl.sv
// Controller: sequences search, scaling, divide and output word for one request.
module blcm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  blcm_pkg::dp_status_type       status,
   output blcm_pkg::dp_cmd_type          cmd
);

   localparam int CW = blcm_pkg::CNT_W;

   blcm_pkg::state_type           state_ff, state_in;
   logic [blcm_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blcm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = blcm_pkg::ST_PREP;
            end
         end
         blcm_pkg::ST_PREP: begin
            if (!status.recover && status.needs_curve) begin
               state_in = blcm_pkg::ST_SRCH_MUL;
            end else begin
               state_in = blcm_pkg::ST_FINISH;
            end
         end
         blcm_pkg::ST_SRCH_MUL: state_in = blcm_pkg::ST_SRCH_CMP;
         blcm_pkg::ST_SRCH_CMP: begin
            if (bit_ff == '0) begin
               state_in = blcm_pkg::ST_SCALE;
            end else begin
               state_in = blcm_pkg::ST_SRCH_MUL;
            end
         end
         blcm_pkg::ST_SCALE: begin
            if (cnt_ff == CW'(blcm_pkg::SCALE_OPS)) begin
               state_in = blcm_pkg::ST_MULT;
            end
         end
         blcm_pkg::ST_MULT: state_in = blcm_pkg::ST_DIV;
         blcm_pkg::ST_DIV: begin
            if (cnt_ff == CW'(blcm_pkg::DIV_STEPS - 1)) begin
               state_in = blcm_pkg::ST_INTERP;
            end
         end
         blcm_pkg::ST_INTERP: state_in = blcm_pkg::ST_FINISH;
         blcm_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = blcm_pkg::ST_IDLE;
            end
         end
         default: state_in = blcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.srch_bit = bit_ff;
      case (state_ff)
         blcm_pkg::ST_IDLE:     cmd.load_req = req_valid;
         blcm_pkg::ST_PREP:     cmd.prep = 1'b1;
         blcm_pkg::ST_SRCH_MUL: cmd.srch_mul = 1'b1;
         blcm_pkg::ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
         blcm_pkg::ST_SCALE: begin
            cmd.scale_issue   = cnt_ff < CW'(blcm_pkg::SCALE_OPS);
            cmd.issue_opd     = blcm_pkg::scale_opd_type'(cnt_ff[1:0]);
            cmd.scale_capture = cnt_ff != '0;
            cmd.capture_opd   = blcm_pkg::scale_opd_type'(cnt_ff[1:0] - 2'd1);
         end
         blcm_pkg::ST_MULT:     cmd.mult_start = 1'b1;
         blcm_pkg::ST_DIV:      cmd.div_step = 1'b1;
         blcm_pkg::ST_INTERP:   cmd.interp_load = 1'b1;
         blcm_pkg::ST_FINISH:   cmd.emit = out_free;
         default: ;
      endcase
   end

   always_comb begin
      bit_in = bit_ff;
      if (state_ff == blcm_pkg::ST_PREP) begin
         bit_in = blcm_pkg::BIT_W'(blcm_pkg::SEG_W - 1);
      end else if (state_ff == blcm_pkg::ST_SRCH_CMP) begin
         bit_in = bit_ff - blcm_pkg::BIT_W'(1);
      end
      cnt_in = (state_ff == blcm_pkg::ST_SCALE || state_ff == blcm_pkg::ST_DIV)
               ? cnt_ff + CW'(1) : '0;
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blcm_pkg::ST_IDLE;
         bit_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != blcm_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("output word overwritten while stalled");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.emit) |=> !rsp_valid_ff)
      else $error("taken output word still shown as valid");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blcm_pkg::ST_DIV) |=>
      (state_ff == blcm_pkg::ST_DIV || state_ff == blcm_pkg::ST_INTERP))
      else $error("divide sequence left early");

endmodule

FILE: rtl/backlight_curve_mapper.sv
// Top level of the backlight curve mapper: controller plus datapath.
// A request word is taken only while the block is idle; its result word sits in an
// output register, so a new request may be taken while that word waits. A recover
// request, or a level that bypasses the curve (zero, at or above the max level),
// goes through the prepare and finish states before its result word is registered.
// A level on the curve goes through a binary search for the segment (a multiply
// and a compare state per index bit through the shared breakpoint multiplier), four
// scaled breakpoints from the same multiplier, one product, and a one-bit-per-cycle
// divider over the 12 result bits; the finish state then writes the result word.
module backlight_curve_mapper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [blcm_pkg::REQ_W-1:0]            req_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [3:0]                            rsp_level_high,
   output logic [7:0]                            rsp_level_low,
   output logic [blcm_pkg::LEVEL_W-1:0]          rsp_applied_level,
   input  logic                                  csr_write,
   input  logic [blcm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [blcm_pkg::CSR_W-1:0]            csr_data
);

   blcm_pkg::dp_cmd_type    cmd;
   blcm_pkg::dp_status_type status;

   blcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   blcm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_level         (req_level),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_level_high    (rsp_level_high),
      .rsp_level_low     (rsp_level_low),
      .rsp_applied_level (rsp_applied_level)
   );

endmodule
